// ----- rtl/apm_pkg.sv -----
// Package for the averaged piecewise pressure map: widths, calibration
// breakpoints in Q12.8 code units, state and handshake types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package apm_pkg;

  localparam int unsigned ADC_BITS    = 12;
  localparam int unsigned MAX_SAMPLES = 64;

  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned AVG_W      = 20;
  localparam int unsigned PRESS_W    = 12;
  localparam int unsigned DIVIDEND_W = SUM_W + FRAC_W;
  localparam int unsigned REM_W      = 15;
  localparam int unsigned ITER_W     = 5;
  localparam int unsigned SEG_W      = 4;
  localparam int unsigned SEG_Q_W    = 9;
  localparam int unsigned NUM_W      = REM_W + FRAC_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(10);
  localparam logic [COUNT_W-1:0] MAX_COUNT    = COUNT_W'(MAX_SAMPLES);
  localparam logic [SEG_W-1:0]   FIRST_SEG    = SEG_W'(1);
  localparam logic [SEG_W-1:0]   LAST_SEG     = SEG_W'(8);
  localparam logic [PRESS_W-1:0] PRESS_OVER   = PRESS_W'(2048);
  localparam logic [PRESS_W-1:0] PRESS_SEG_MAX = PRESS_W'(1920);
  localparam logic [AVG_W-1:0]   AVG_MAX      = AVG_W'(((2 ** ADC_BITS) - 1) * 256);
  localparam logic [ITER_W-1:0]  AVG_ITERS    = ITER_W'(DIVIDEND_W);
  localparam logic [ITER_W-1:0]  SEG_ITERS    = ITER_W'(SEG_Q_W);

  // Voltages are in units of 10 uV; codes are rounded to nearest at 3.3 V full scale.
  localparam longint unsigned FULL_Q8 = ((64'd1 << ADC_BITS) - 64'd1) * 64'd256;
  localparam longint unsigned HALF_FS = 64'd165000;
  localparam longint unsigned FS_VOLT = 64'd330000;

  localparam logic [AVG_W-1:0] ZERO_CODE = AVG_W'((64'd1870 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_0 = AVG_W'((64'd1866 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_1 = AVG_W'((64'd9296 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_2 = AVG_W'((64'd13836 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_3 = AVG_W'((64'd16890 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_4 = AVG_W'((64'd19740 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_5 = AVG_W'((64'd21561 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_6 = AVG_W'((64'd23354 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_7 = AVG_W'((64'd24952 * FULL_Q8 + HALF_FS) / FS_VOLT);
  localparam logic [AVG_W-1:0] BRK_8 = AVG_W'((64'd25500 * FULL_Q8 + HALF_FS) / FS_VOLT);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV_AVG,
    ST_CLASSIFY,
    ST_SEARCH,
    ST_DIV_SEG,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [AVG_W-1:0] brk_code(input logic [SEG_W-1:0] k);
    logic [AVG_W-1:0] code;
    case (k)
      4'd0:    code = BRK_0;
      4'd1:    code = BRK_1;
      4'd2:    code = BRK_2;
      4'd3:    code = BRK_3;
      4'd4:    code = BRK_4;
      4'd5:    code = BRK_5;
      4'd6:    code = BRK_6;
      4'd7:    code = BRK_7;
      4'd8:    code = BRK_8;
      default: code = BRK_8;
    endcase
    return code;
  endfunction

  function automatic logic [PRESS_W-1:0] brk_press(input logic [SEG_W-1:0] k);
    logic [PRESS_W-1:0] press;
    case (k)
      4'd0:    press = PRESS_W'(0);
      4'd1:    press = PRESS_W'(256);
      4'd2:    press = PRESS_W'(512);
      4'd3:    press = PRESS_W'(768);
      4'd4:    press = PRESS_W'(1024);
      4'd5:    press = PRESS_W'(1280);
      4'd6:    press = PRESS_W'(1536);
      4'd7:    press = PRESS_W'(1792);
      4'd8:    press = PRESS_SEG_MAX;
      default: press = PRESS_SEG_MAX;
    endcase
    return press;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/apm_serial_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Depends on apm_pkg for widths and the command and status structs.
`default_nettype none

module apm_serial_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  apm_pkg::div_cmd_t              cmd_i,
  input  logic [apm_pkg::REM_W-1:0]      rem_init_i,
  input  logic [apm_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [apm_pkg::REM_W-1:0]      divisor_i,
  output apm_pkg::div_sts_t              sts_o,
  output logic [apm_pkg::DIVIDEND_W-1:0] quotient_o
);
  import apm_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [ITER_W-1:0]     cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0]      div_q, div_d;
  logic [REM_W:0]        trial;
  logic [REM_W:0]        diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = cmd_i.iters;
      rem_d  = rem_init_i;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/averaged_piecewise_pressure_map_core.sv -----
// After the word that closes a group the divider forms the average, then the block
// classifies it: at or below the zero threshold or above the last breakpoint the result
// is ready, else the segments are tested in turn and the segment slope is divided.
// Throughput: one word per cycle within a group; after the closing word no word is taken
// until the result reaches the output, which waits for the previous result to be taken.
// Reset clears the running sum, the sample counter and the output valid; the count is 10.
`default_nettype none

module averaged_piecewise_pressure_map_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [apm_pkg::ADC_BITS-1:0] adc_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [apm_pkg::PRESS_W-1:0]  pressure_q8_o,
  output logic [apm_pkg::AVG_W-1:0]    average_code_q8_o,
  output logic                         over_range_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [apm_pkg::COUNT_W-1:0]  cfg_wdata_i
);
  import apm_pkg::*;

  state_e                state_q, state_d;
  logic [COUNT_W-1:0]    sample_count_q;
  logic [SUM_W-1:0]      sum_q;
  logic [COUNT_W-1:0]    taken_q;
  logic [SEG_W-1:0]      seg_q;
  logic [AVG_W-1:0]      avg_q;
  logic [PRESS_W-1:0]    base_q;
  logic [PRESS_W-1:0]    res_press_q;
  logic                  res_over_q;
  logic                  out_valid_q;
  logic [PRESS_W-1:0]    pressure_q;
  logic [AVG_W-1:0]      average_q;
  logic                  over_q;

  logic [COUNT_W-1:0]    eff_count;
  logic                  in_fire;
  logic [SUM_W-1:0]      sum_next;
  logic [COUNT_W-1:0]    taken_next;
  logic                  group_done;
  logic                  is_zero;
  logic                  is_over;
  logic                  seg_hit;
  logic [REM_W-1:0]      dx;
  logic [NUM_W-1:0]      num;
  logic                  out_load;

  div_cmd_t              div_cmd;
  div_sts_t              div_sts;
  logic [REM_W-1:0]      div_rem_init;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [REM_W-1:0]      div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;

  always_comb begin
    if (sample_count_q == '0) begin
      eff_count = COUNT_W'(1);
    end else if (sample_count_q > MAX_COUNT) begin
      eff_count = MAX_COUNT;
    end else begin
      eff_count = sample_count_q;
    end
  end

  assign in_ready_o = (state_q == ST_ACC);
  assign in_fire    = in_valid_i && in_ready_o;
  assign sum_next   = sum_q + SUM_W'(adc_sample_i);
  assign taken_next = taken_q + COUNT_W'(1);
  assign group_done = taken_next >= eff_count;

  assign is_zero = avg_q <= ZERO_CODE;
  assign is_over = avg_q > brk_code(LAST_SEG);
  assign seg_hit = avg_q <= brk_code(seg_q);
  assign dx      = REM_W'(avg_q - brk_code(seg_q - SEG_W'(1)));
  assign num     = (seg_q == LAST_SEG) ? {1'b0, dx, 7'b0} : {dx, 8'b0};
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC: begin
        if (in_fire && group_done) state_d = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_sts.done) state_d = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        state_d = (is_zero || is_over) ? ST_DONE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (seg_hit) state_d = ST_DIV_SEG;
      end
      ST_DIV_SEG: begin
        if (div_sts.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_ACC;
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_comb begin
    div_cmd      = '0;
    div_rem_init = '0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      ST_ACC: begin
        if (in_fire && group_done) begin
          div_cmd.start = 1'b1;
          div_cmd.iters = AVG_ITERS;
          div_dividend  = {sum_next, {FRAC_W{1'b0}}};
          div_divisor   = REM_W'(taken_next);
        end
      end
      ST_SEARCH: begin
        if (seg_hit) begin
          div_cmd.start = 1'b1;
          div_cmd.iters = SEG_ITERS;
          div_rem_init  = REM_W'(num[NUM_W-1:SEG_Q_W]);
          div_dividend  = {num[SEG_Q_W-1:0], {(DIVIDEND_W - SEG_Q_W){1'b0}}};
          div_divisor   = REM_W'(brk_code(seg_q) - brk_code(seg_q - SEG_W'(1)));
        end
      end
      default: begin
        div_cmd = '0;
      end
    endcase
  end

  apm_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_ACC;
      sample_count_q <= COUNT_RESET;
      sum_q          <= '0;
      taken_q        <= '0;
      seg_q          <= FIRST_SEG;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) sample_count_q <= cfg_wdata_i;
      if (in_fire) begin
        sum_q   <= group_done ? '0 : sum_next;
        taken_q <= group_done ? '0 : taken_next;
      end
      if (state_q == ST_CLASSIFY) begin
        seg_q <= FIRST_SEG;
      end else if (state_q == ST_SEARCH && !seg_hit) begin
        seg_q <= seg_q + SEG_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_AVG && div_sts.done) avg_q <= div_quotient[AVG_W-1:0];
    if (state_q == ST_CLASSIFY) begin
      res_press_q <= is_over ? PRESS_OVER : '0;
      res_over_q  <= is_over && !is_zero;
    end
    if (state_q == ST_SEARCH && seg_hit) base_q <= brk_press(seg_q - SEG_W'(1));
    if (state_q == ST_DIV_SEG && div_sts.done) begin
      res_press_q <= base_q + PRESS_W'(div_quotient[SEG_Q_W-1:0]);
      res_over_q  <= 1'b0;
    end
    if (out_load) begin
      pressure_q <= res_press_q;
      average_q  <= avg_q;
      over_q     <= res_over_q;
    end
  end

  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign pressure_q8_o     = pressure_q;
  assign average_code_q8_o = average_q;
  assign over_range_o      = over_q;

endmodule

`default_nettype wire

// ----- rtl/apm_checker.sv -----
// Port-level checks for the pressure map core and the bind that attaches them.
// Depends on apm_pkg for widths and limit constants.
`default_nettype none

module apm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [apm_pkg::PRESS_W-1:0]  pressure_q8_o,
  input logic [apm_pkg::AVG_W-1:0]    average_code_q8_o,
  input logic                         over_range_o
);
  import apm_pkg::*;

  // A word that is not taken must stay put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pressure_q8_o)
      && $stable(average_code_q8_o) && $stable(over_range_o))
    else $error("Result word changed while stalled.");

  // Over range always reports full scale pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_range_o |-> pressure_q8_o == PRESS_OVER)
    else $error("Over range without full scale pressure.");

  // Inside the calibrated span the pressure never exceeds the last segment end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !over_range_o |-> pressure_q8_o <= PRESS_SEG_MAX)
    else $error("Pressure beyond last segment.");

  // An average can never exceed the full converter code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> average_code_q8_o <= AVG_MAX)
    else $error("Average above full scale.");

  // An average at or below the zero threshold is never flagged as over range and gives zero pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && average_code_q8_o <= ZERO_CODE |-> !over_range_o && pressure_q8_o == '0)
    else $error("Average below threshold gave nonzero pressure.");

endmodule

bind averaged_piecewise_pressure_map_core apm_checker u_apm_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for averaged_piecewise_pressure_map_core. It drives ADC words and
// sample-count writes, predicts every averaged pressure reading and compares it field by field.
// Depends on apm_pkg and the core RTL.

module tb_top;
  import apm_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int WORDS_PER_MODE = 550;
  localparam int unsigned OVER_PRESSURE = 2048;
  localparam int unsigned SENSOR_TOP = 340;
  localparam int unsigned CODE_TOP = (1 << ADC_BITS) - 1;

  typedef struct packed {
    logic [PRESS_W-1:0] pressure;
    logic [AVG_W-1:0]   average;
    logic               over;
  } reading_t;

  class pressure_scoreboard;
    logic [COUNT_W-1:0] group_len;
    logic [SUM_W-1:0]   run_sum;
    logic [COUNT_W-1:0] run_taken;
    logic [AVG_W-1:0]   zero_code;
    logic [AVG_W-1:0]   knot_code[9];
    logic [PRESS_W-1:0] knot_press[9];
    reading_t           due_q[$];
    int unsigned        fail_cnt;

    function new();
      int unsigned knot_volt[9] = '{1866, 9296, 13836, 16890, 19740, 21561, 23354, 24952,
                                    25500};
      group_len = COUNT_W'(10);
      run_sum   = '0;
      run_taken = '0;
      fail_cnt  = 0;
      zero_code = volt_code(1870);
      for (int k = 0; k < 9; k++) begin
        knot_code[k]  = volt_code(knot_volt[k]);
        knot_press[k] = (k == 8) ? PRESS_W'(1920) : PRESS_W'(256 * k);
      end
    endfunction

    function logic [AVG_W-1:0] volt_code(longint unsigned volt);
      longint unsigned full_q8;
      full_q8 = ((64'd1 << ADC_BITS) - 1) * 256;
      return AVG_W'((volt * full_q8 + 165000) / 330000);
    endfunction

    function logic [COUNT_W-1:0] active_len();
      if (group_len == 0) return COUNT_W'(1);
      if (group_len > MAX_SAMPLES) return COUNT_W'(MAX_SAMPLES);
      return group_len;
    endfunction

    function void note_sample(logic [ADC_BITS-1:0] w);
      reading_t              r;
      logic [DIVIDEND_W-1:0] scaled;
      longint unsigned       dx;
      longint unsigned       span;
      bit                    hit;
      run_sum   += SUM_W'(w);
      run_taken += COUNT_W'(1);
      if (run_taken < active_len()) return;
      scaled     = DIVIDEND_W'(run_sum) << FRAC_W;
      r.average  = AVG_W'(scaled / DIVIDEND_W'(run_taken));
      r.pressure = '0;
      r.over     = 1'b0;
      if (r.average <= zero_code) begin
        r.pressure = '0;
      end else if (r.average > knot_code[8]) begin
        r.pressure = PRESS_W'(OVER_PRESSURE);
        r.over     = 1'b1;
      end else begin
        hit = 1'b0;
        for (int k = 1; k < 9; k++) begin
          if (!hit && r.average <= knot_code[k]) begin
            hit        = 1'b1;
            span       = knot_code[k] - knot_code[k-1];
            dx         = (r.average > knot_code[k-1]) ? r.average - knot_code[k-1] : 0;
            r.pressure = knot_press[k-1];
            if (span != 0)
              r.pressure += PRESS_W'(dx * (knot_press[k] - knot_press[k-1]) / span);
          end
        end
      end
      run_sum   = '0;
      run_taken = '0;
      due_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_cnt++;
    endtask

    task check_result(logic [PRESS_W-1:0] pressure, logic [AVG_W-1:0] average, logic over);
      reading_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected reading pressure %0d average %0d over %0d",
                         pressure, average, over));
        return;
      end
      want = due_q.pop_front();
      if (pressure !== want.pressure)
        report($sformatf("pressure_q8 got %0d want %0d", pressure, want.pressure));
      if (average !== want.average)
        report($sformatf("average_code_q8 got %0d want %0d", average, want.average));
      if (over !== want.over)
        report($sformatf("over_range got %0d want %0d", over, want.over));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ADC_BITS-1:0] adc_sample_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [PRESS_W-1:0]  pressure_q8_o;
  logic [AVG_W-1:0]    average_code_q8_o;
  logic                over_range_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [COUNT_W-1:0]  cfg_wdata_i;

  pressure_scoreboard  sb;
  logic [ADC_BITS-1:0] group_words[$];
  logic [ADC_BITS-1:0] corner_words[13] = '{0, 23, 24, 115, 172, 209, 245, 268, 290, 310,
                                            316, 317, 4095};
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int                  sent_words = 0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;
  logic                hold_req;
  logic                hold_taken = 1'b0;

  averaged_piecewise_pressure_map_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .adc_sample_i      (adc_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pressure_q8_o     (pressure_q8_o),
    .average_code_q8_o (average_code_q8_o),
    .over_range_o      (over_range_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(pressure_q8_o, average_code_q8_o, over_range_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [ADC_BITS-1:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(w);
    sent_words++;
  endtask

  task automatic write_length(input logic [COUNT_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    sb.group_len = v;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void fill_group(int unsigned n);
    int unsigned pick;
    int unsigned spread;
    int unsigned target;
    int unsigned total;
    int unsigned base;
    int unsigned extra;
    int unsigned knot;
    int unsigned j;
    int unsigned d;
    group_words.delete();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // Average placed just around a breakpoint or the zero threshold.
      spread = 256 / n + 3;
      knot   = $urandom_range(0, 9);
      target = ((knot == 9) ? sb.zero_code : sb.knot_code[knot]);
      target = target + $urandom_range(0, 2 * spread) - spread;
      total  = (target * n + 255) / 256;
      base   = total / n;
      extra  = total % n;
      for (int unsigned i = 0; i < n; i++)
        group_words.push_back(ADC_BITS'(base + (i < extra)));
      for (int unsigned i = 0; i < n; i++) begin
        j = $urandom_range(0, n - 1);
        d = $urandom_range(0, 3);
        if (group_words[i] >= d && group_words[j] + d <= CODE_TOP) begin
          group_words[i] -= ADC_BITS'(d);
          group_words[j] += ADC_BITS'(d);
        end
      end
    end else if (pick < 75) begin
      for (int unsigned i = 0; i < n; i++)
        group_words.push_back(ADC_BITS'($urandom_range(0, SENSOR_TOP)));
    end else if (pick < 90) begin
      for (int unsigned i = 0; i < n; i++)
        group_words.push_back(ADC_BITS'($urandom_range(0, CODE_TOP)));
    end else begin
      d = $urandom_range(0, 2);
      for (int unsigned i = 0; i < n; i++) begin
        if (d == 0) group_words.push_back('0);
        else if (d == 1) group_words.push_back(ADC_BITS'(CODE_TOP));
        else group_words.push_back(i[0] ? ADC_BITS'(CODE_TOP) : '0);
      end
    end
  endfunction

  initial begin
    int unsigned        setting_idx;
    int unsigned        eff;
    int unsigned        groups;
    int unsigned        part;
    logic [COUNT_W-1:0] len_value;
    sb           = new();
    setting_idx  = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    adc_sample_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_wdata_i  <= '0;
    hold_req     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset count of ten closes the first group.
    repeat (10) send_word(ADC_BITS'(CODE_TOP));
    drain_results();
    write_length(COUNT_W'(1));
    foreach (corner_words[i]) send_word(corner_words[i]);
    drain_results();
    write_length(COUNT_W'(0));
    send_word(ADC_BITS'(24));
    drain_results();
    // Shortening the count inside a group closes it on the next word.
    write_length(COUNT_W'(8));
    send_word(ADC_BITS'(200));
    send_word(ADC_BITS'(210));
    send_word(ADC_BITS'(220));
    drain_results();
    write_length(COUNT_W'(2));
    send_word(ADC_BITS'(230));

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 85 : 0;
      recv_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 33 : 0;
      if (mode == 2) begin
        // The receiver stalls for a long stretch so the block backs up its input.
        drain_results();
        write_length(COUNT_W'(1));
        hold_req <= 1'b1;
        repeat (24) send_word(ADC_BITS'($urandom_range(0, SENSOR_TOP)));
      end
      while (sent_words < WORDS_PER_MODE * (mode + 1)) begin
        case (setting_idx % 8)
          0:       len_value = COUNT_W'(1);
          1:       len_value = COUNT_W'(0);
          2:       len_value = COUNT_W'(127);
          3:       len_value = COUNT_W'(2);
          4:       len_value = COUNT_W'(MAX_SAMPLES);
          5:       len_value = COUNT_W'($urandom_range(3, 16));
          6:       len_value = COUNT_W'(1);
          default: len_value = COUNT_W'($urandom_range(17, 126));
        endcase
        setting_idx++;
        drain_results();
        write_length(len_value);
        eff    = sb.active_len();
        groups = (eff >= 32) ? 2 : 48 / eff + 1;
        repeat (groups) begin
          fill_group(eff);
          foreach (group_words[i]) send_word(group_words[i]);
        end
        fill_group(eff);
        part = $urandom_range(0, eff - 1);
        for (int unsigned i = 0; i < part; i++) send_word(group_words[i]);
      end
    end

    drain_results();
    if (sb.fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/apm_pkg.sv
rtl/apm_serial_div.sv
rtl/averaged_piecewise_pressure_map_core.sv
rtl/apm_checker.sv
tb/tb_top.sv
